/* sv/vev_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vev_pkg
// Shared widths, constants and helpers for the Vreman eddy viscosity pipeline.
// ----------------------------------------------------------------------------
package vev_pkg;

  localparam int GRAD_W  = 32;   // signed Q12.20 gradient
  localparam int SPC_W   = 32;   // unsigned Q0.32 spacing
  localparam int COEF_W  = 16;   // unsigned Q0.16 coefficient
  localparam int OUT_W   = 32;   // unsigned Q8.24 viscosity

  localparam int AA_W    = 66;   // sum of nine squared gradients
  localparam int BS_W    = 258;  // invariant B, exact
  localparam int NUM_LSB = 120;  // B is scaled down by 2^120 before division
  localparam int NDIV    = 96;   // quotient bits kept, one per stage
  localparam int TOP_W   = BS_W - NUM_LSB - NDIV;
  localparam int NROOT   = NDIV / 2;
  localparam int SREM_W  = NROOT + 2;

  localparam int NFRONT  = 13;   // product and accumulation stages
  localparam int NST     = NFRONT + (NDIV + 1) + (NROOT + 1) + 1;

  localparam logic [NDIV-1:0]   THRESH_CODE = NDIV'(2814749);
  localparam logic [COEF_W-1:0] COEF_RESET  = COEF_W'(4588);

  typedef struct packed {
    logic zero;   // all gradients are zero
    logic big;    // quotient does not fit the kept bits
    logic pass;   // ratio is above the threshold
  } vev_flags_t;

  // Index pairs (0,1), (0,2), (1,2) used for the 2x2 minors.
  function automatic int pair_lo(input int p);
    return (p == 2) ? 1 : 0;
  endfunction

  function automatic int pair_hi(input int p);
    return (p == 0) ? 1 : 2;
  endfunction

  // Flat port order of the gradient a_mi = d u_i / d x_m.
  function automatic int grad_idx(input int m, input int i);
    return i * 3 + m;
  endfunction

endpackage
`default_nettype wire

/* sv/vreman_eddy_viscosity.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vreman_eddy_viscosity
// Vreman sub-grid eddy viscosity, one grid point per transfer, fully pipelined.
// ----------------------------------------------------------------------------
// Path: a result is presented from the output register, after its input has
// passed through the 160 pipeline registers (the first of which loads at the
// edge of the transfer).
// Throughput: one transfer per cycle while the skid register is empty; the
// 96-step quotient and 48-step root chains retire one bit per pipeline stage.
// Reset: rst_n is synchronous, active low; it empties the pipeline and the
// output stage and restores the coefficient register coef_r to 4588.
// ----------------------------------------------------------------------------
module vreman_eddy_viscosity (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_xx,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_xy,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_xz,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_yx,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_yy,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_yz,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_zx,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_zy,
  input  wire  [vev_pkg::GRAD_W-1:0]   in_grad_zz,
  input  wire  [vev_pkg::SPC_W-1:0]    in_spacing_x,
  input  wire  [vev_pkg::SPC_W-1:0]    in_spacing_y,
  input  wire  [vev_pkg::SPC_W-1:0]    in_spacing_z,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [vev_pkg::OUT_W-1:0]    out_eddy_viscosity,
  output logic                         out_saturated,
  input  wire                          cfg_write_en,
  input  wire  [vev_pkg::COEF_W-1:0]   cfg_write_data
);
  import vev_pkg::*;

  // --------------------------------------------------------------------------
  // Control. The whole pipeline moves together while the skid register is
  // empty. When the output register is stalled, the item leaving the last
  // stage parks in the skid register, and only then does the pipeline halt.
  // So one more transfer is taken while a finished result waits.
  // --------------------------------------------------------------------------
  logic [NST-1:0]    v_r;
  logic              en;
  logic              out_valid_r, skid_vld_r;
  logic [OUT_W-1:0]  out_visc_r, skid_visc_r;
  logic              out_sat_r, skid_sat_r;
  logic [COEF_W-1:0] coef_r;
  logic              out_take, out_free, leaving;

  assign en       = !skid_vld_r;
  assign in_ready = en;
  assign out_take = out_valid_r && out_ready;
  assign out_free = !out_valid_r || out_take;
  assign leaving  = en && v_r[NST-1];

  // Gradients are regrouped as g[m][i] = d u_i / d x_m in flat order.
  logic signed [GRAD_W-1:0] gin [9];
  logic        [SPC_W-1:0]  spc [3];

  always_comb begin
    gin[0] = in_grad_xx;  gin[1] = in_grad_xy;  gin[2] = in_grad_xz;
    gin[3] = in_grad_yx;  gin[4] = in_grad_yy;  gin[5] = in_grad_yz;
    gin[6] = in_grad_zx;  gin[7] = in_grad_zy;  gin[8] = in_grad_zz;
    spc[0] = in_spacing_x;
    spc[1] = in_spacing_y;
    spc[2] = in_spacing_z;
  end

  // --------------------------------------------------------------------------
  // Front stages. The invariant B is the sum, over row pairs (m,n), of
  // (d_m d_n)^2 times the sum of the squared 2x2 minors of those rows. Every
  // multiplication is 32x32 or split into 32-bit limbs, and each stage holds
  // at most one wide addition per value.
  // --------------------------------------------------------------------------
  logic signed [63:0]  mpa_r [3][3];   // S1 minor products
  logic signed [63:0]  mpb_r [3][3];
  logic        [63:0]  dd_r  [3];      // S1 d_m * d_n
  logic        [63:0]  gsq_r [9];      // S1 squared gradients
  logic signed [63:0]  dif_r [3][3];   // S2 signed minors
  logic        [AA_W-1:0] aa3_r [3];   // S2 partial sums of squares
  logic        [63:0]  ddll_r [3], ddhh_r [3], ddhl_r [3];
  logic        [62:0]  mag_r [3][3];   // S3 minor magnitudes
  logic        [AA_W-1:0] aa_r [3:NFRONT];
  logic        [127:0] w_r [3:7][3];   // (d_m d_n)^2
  logic        [63:0]  mll_r [3][3], mhh_r [3][3], mhl_r [3][3];
  logic        [127:0] msq_r [3][3];   // S5 squared minors
  logic        [127:0] sp_r [3], sq2_r [3];
  logic        [127:0] s_r [3];        // S7 minor sum per row pair
  logic        [63:0]  pp_r [3][4][4]; // S8 limb products
  logic        [159:0] row_r [3][4];
  logic        [255:0] half_r [3][2];
  logic        [255:0] t_r [3];        // S11 term per row pair
  logic        [BS_W-1:0] b01_r;
  logic        [255:0] t2d_r;
  logic        [BS_W-1:0] bsum_r;      // S13 invariant B

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          mpa_r[p][c] <= 64'(gin[grad_idx(pair_lo(p), pair_lo(c))]) *
                         64'(gin[grad_idx(pair_hi(p), pair_hi(c))]);
          mpb_r[p][c] <= 64'(gin[grad_idx(pair_lo(p), pair_hi(c))]) *
                         64'(gin[grad_idx(pair_hi(p), pair_lo(c))]);
        end
        dd_r[p] <= 64'(spc[pair_lo(p)]) * 64'(spc[pair_hi(p)]);
      end
      for (int k = 0; k < 9; k++) begin
        gsq_r[k] <= 64'(64'(gin[k]) * 64'(gin[k]));
      end

      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          dif_r[p][c] <= mpa_r[p][c] - mpb_r[p][c];
        end
        aa3_r[p]  <= AA_W'(gsq_r[3*p]) + AA_W'(gsq_r[3*p+1]) + AA_W'(gsq_r[3*p+2]);
        ddll_r[p] <= 64'(dd_r[p][31:0]) * 64'(dd_r[p][31:0]);
        ddhh_r[p] <= 64'(dd_r[p][63:32]) * 64'(dd_r[p][63:32]);
        ddhl_r[p] <= 64'(dd_r[p][63:32]) * 64'(dd_r[p][31:0]);
      end

      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          mag_r[p][c] <= dif_r[p][c][63] ? 63'(-dif_r[p][c]) : dif_r[p][c][62:0];
        end
        w_r[3][p] <= {ddhh_r[p], ddll_r[p]} + (128'(ddhl_r[p]) << 33);
      end
      aa_r[3] <= aa3_r[0] + aa3_r[1] + aa3_r[2];
      for (int k = 4; k <= NFRONT; k++) begin
        aa_r[k] <= aa_r[k-1];
      end
      for (int k = 4; k <= 7; k++) begin
        w_r[k] <= w_r[k-1];
      end

      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          mll_r[p][c] <= 64'(mag_r[p][c][31:0]) * 64'(mag_r[p][c][31:0]);
          mhh_r[p][c] <= 64'(mag_r[p][c][62:32]) * 64'(mag_r[p][c][62:32]);
          mhl_r[p][c] <= 64'(mag_r[p][c][62:32]) * 64'(mag_r[p][c][31:0]);
          msq_r[p][c] <= {mhh_r[p][c], mll_r[p][c]} + (128'(mhl_r[p][c]) << 33);
        end
        sp_r[p]  <= msq_r[p][0] + msq_r[p][1];
        sq2_r[p] <= msq_r[p][2];
        s_r[p]   <= sp_r[p] + sq2_r[p];
      end

      // 128 x 128 product as 16 limb products, then rows, halves and total.
      for (int p = 0; p < 3; p++) begin
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            pp_r[p][i][j] <= 64'(w_r[7][p][32*i +: 32]) * 64'(s_r[p][32*j +: 32]);
          end
          row_r[p][i] <= 160'({pp_r[p][i][2], pp_r[p][i][0]}) +
                         (160'({pp_r[p][i][3], pp_r[p][i][1]}) << 32);
        end
        half_r[p][0] <= 256'(row_r[p][0]) + (256'(row_r[p][1]) << 32);
        half_r[p][1] <= (256'(row_r[p][2]) << 64) + (256'(row_r[p][3]) << 96);
        t_r[p]       <= half_r[p][0] + half_r[p][1];
      end
      b01_r  <= BS_W'(t_r[0]) + BS_W'(t_r[1]);
      t2d_r  <= t_r[2];
      bsum_r <= b01_r + BS_W'(t2d_r);
    end
  end

  // --------------------------------------------------------------------------
  // Quotient chain: floor((B >> 120) / aa), restoring, one bit per stage.
  // The bits above the kept 96 only decide whether the quotient overflows.
  // When it does not, they are already smaller than aa and form the first
  // partial remainder.
  // --------------------------------------------------------------------------
  logic [AA_W-1:0]  dv_rem_r [0:NDIV];
  logic [NDIV-1:0]  dv_dq_r  [0:NDIV];
  logic [AA_W-1:0]  dv_aa_r  [0:NDIV];
  vev_flags_t       dv_fl_r  [0:NDIV];
  logic [AA_W:0]    dv_trial [NDIV];
  logic             dv_ge    [NDIV];
  logic [AA_W-1:0]  dv_rem_nxt [NDIV];
  logic [NDIV-1:0]  dv_dq_nxt  [NDIV];
  logic [TOP_W-1:0] num_top;

  assign num_top = bsum_r[BS_W-1 -: TOP_W];

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      dv_trial[k]   = {dv_rem_r[k], dv_dq_r[k][NDIV-1]};
      dv_ge[k]      = dv_trial[k] >= {1'b0, dv_aa_r[k]};
      dv_rem_nxt[k] = dv_ge[k] ? AA_W'(dv_trial[k] - {1'b0, dv_aa_r[k]})
                               : dv_trial[k][AA_W-1:0];
      dv_dq_nxt[k]  = {dv_dq_r[k][NDIV-2:0], dv_ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]     <= AA_W'(num_top);
      dv_dq_r[0]      <= bsum_r[NUM_LSB +: NDIV];
      dv_aa_r[0]      <= aa_r[NFRONT];
      dv_fl_r[0].zero <= (aa_r[NFRONT] == '0);
      dv_fl_r[0].big  <= (AA_W'(num_top) >= aa_r[NFRONT]);
      dv_fl_r[0].pass <= 1'b0;
      for (int k = 0; k < NDIV; k++) begin
        dv_rem_r[k+1] <= dv_rem_nxt[k];
        dv_dq_r[k+1]  <= dv_dq_nxt[k];
        dv_aa_r[k+1]  <= dv_aa_r[k];
        dv_fl_r[k+1]  <= dv_fl_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root chain: floor square root of the 96-bit ratio code, two
  // radicand bits and one root bit per stage.
  // --------------------------------------------------------------------------
  logic [SREM_W-1:0] sq_rem_r  [0:NROOT];
  logic [NROOT-1:0]  sq_root_r [0:NROOT];
  logic [NDIV-1:0]   sq_rad_r  [0:NROOT];
  vev_flags_t        sq_fl_r   [0:NROOT];
  logic [SREM_W+1:0] sq_r2     [NROOT];
  logic [SREM_W+1:0] sq_trial  [NROOT];
  logic              sq_ge     [NROOT];

  always_comb begin
    for (int k = 0; k < NROOT; k++) begin
      sq_r2[k]    = {sq_rem_r[k], sq_rad_r[k][NDIV-1 -: 2]};
      sq_trial[k] = (SREM_W+2)'({sq_root_r[k], 2'b01});
      sq_ge[k]    = sq_r2[k] >= sq_trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]     <= '0;
      sq_root_r[0]    <= '0;
      sq_rad_r[0]     <= dv_dq_r[NDIV];
      sq_fl_r[0].zero <= dv_fl_r[NDIV].zero;
      sq_fl_r[0].big  <= dv_fl_r[NDIV].big;
      sq_fl_r[0].pass <= dv_fl_r[NDIV].big || (dv_dq_r[NDIV] > THRESH_CODE);
      for (int k = 0; k < NROOT; k++) begin
        sq_rem_r[k+1]  <= sq_ge[k] ? SREM_W'(sq_r2[k] - sq_trial[k])
                                   : sq_r2[k][SREM_W-1:0];
        sq_root_r[k+1] <= {sq_root_r[k][NROOT-2:0], sq_ge[k]};
        sq_rad_r[k+1]  <= {sq_rad_r[k][NDIV-3:0], 2'b00};
        sq_fl_r[k+1]   <= sq_fl_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale by the coefficient. The product has 40 fraction bits; dropping 16
  // leaves Q8.24, and anything above 32 bits saturates.
  // --------------------------------------------------------------------------
  logic [NROOT+COEF_W-1:0] prod_r;
  vev_flags_t              mfl_r;
  logic                    coefz_r;
  logic [NROOT-1:0]        scaled;
  logic [OUT_W-1:0]        res_visc;
  logic                    res_sat;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= (NROOT+COEF_W)'(coef_r) * (NROOT+COEF_W)'(sq_root_r[NROOT]);
      mfl_r   <= sq_fl_r[NROOT];
      coefz_r <= (coef_r == '0);
    end
  end

  assign scaled = prod_r[COEF_W +: NROOT];

  always_comb begin
    if (mfl_r.zero || !mfl_r.pass || coefz_r) begin
      res_visc = '0;
      res_sat  = 1'b0;
    end else if (mfl_r.big || (scaled[NROOT-1:OUT_W] != '0)) begin
      res_visc = '1;
      res_sat  = 1'b1;
    end else begin
      res_visc = scaled[OUT_W-1:0];
      res_sat  = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits, configuration register, output and skid registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
      skid_vld_r  <= 1'b0;
      coef_r      <= COEF_RESET;
    end else begin
      if (cfg_write_en) begin
        coef_r <= cfg_write_data;
      end
      if (en) begin
        v_r <= {v_r[NST-2:0], in_valid};
      end
      if (skid_vld_r) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          skid_vld_r  <= 1'b0;
        end
      end else if (leaving) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_free) begin
        out_visc_r <= skid_visc_r;
        out_sat_r  <= skid_sat_r;
      end
    end else if (leaving) begin
      if (out_free) begin
        out_visc_r <= res_visc;
        out_sat_r  <= res_sat;
      end else begin
        skid_visc_r <= res_visc;
        skid_sat_r  <= res_sat;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_eddy_viscosity = out_visc_r;
  assign out_saturated      = out_sat_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The skid register holds a result only behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // The skid register fills only when the output register was stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid register filled without an output stall");

  // A saturated result always carries the all-ones viscosity.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_visc_r == '1))
    else $error("saturation flag without clipped viscosity");

endmodule
`default_nettype wire
